// File: src/ahp_pkg.sv
// ----------------------------------------------------------------------------
// ahp_pkg
// Shared types, constants and the CRC-32 byte update for the archive header
// parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ahp_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [31:0] ARC_MAGIC     = 32'h4c7a5341;
	localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
	localparam logic [15:0] MAX_FILES_RST = 16'd128;

	// byte positions inside a field group
	localparam logic [4:0] WORD_LAST  = 5'd3;
	localparam logic [4:0] FLD0_LAST  = 5'd3;
	localparam logic [4:0] FLD1_LAST  = 5'd7;
	localparam logic [4:0] FLD2_LAST  = 5'd11;
	localparam logic [4:0] FIXED_LAST = 5'd19;

	localparam int START_LEN = 4 + 4;

	localparam int             SUM_BITS = 33;
	localparam logic [32:0]    SUM_MAX  = {SUM_BITS{1'b1}};

	localparam logic RK_ENTRY  = 1'b0;
	localparam logic RK_STATUS = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MAGIC = 3'd1,
		ST_TOO_MANY  = 3'd2,
		ST_TRUNC     = 3'd3,
		ST_HCRC      = 3'd4,
		ST_LEN       = 3'd5
	} status_t;

	typedef enum logic [6:0] {
		PH_MAGIC = 7'b0000001,
		PH_COUNT = 7'b0000010,
		PH_FIXED = 7'b0000100,
		PH_NAME  = 7'b0001000,
		PH_HCRC  = 7'b0010000,
		PH_DATA  = 7'b0100000,
		PH_FAIL  = 7'b1000000
	} phase_t;

	// one queue slot: everything a single input byte produces
	typedef struct packed {
		logic        has_entry;
		logic        has_status;
		logic [15:0] entry_index;
		logic [31:0] uncompressed_size;
		logic [31:0] compressed_size;
		logic [31:0] data_checksum;
		logic [63:0] modified_time;
		logic [31:0] name_offset;
		logic [31:0] data_offset;
		status_t     status;
		logic [31:0] file_count;
	} cmd_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: src/ahp_ifs.sv
// ----------------------------------------------------------------------------
// ahp channel interfaces
// Byte input, record output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface ahp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;

	modport source(output valid, output data_byte, output is_last, input ready);
	modport sink(input valid, input data_byte, input is_last, output ready);
endinterface

interface ahp_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] max_files;

	modport source(output valid, output max_files, input ready);
	modport sink(input valid, input max_files, output ready);
endinterface

interface ahp_rec_if;
	logic        valid;
	logic        ready;
	logic        record_kind;
	logic [15:0] entry_index;
	logic [31:0] uncompressed_size;
	logic [31:0] compressed_size;
	logic [31:0] data_checksum;
	logic [63:0] modified_time;
	logic [31:0] name_offset;
	logic [31:0] data_offset;
	logic [2:0]  status;
	logic [31:0] file_count;
	logic        last_of_run;

	modport source(
		output valid, output record_kind, output entry_index,
		output uncompressed_size, output compressed_size, output data_checksum,
		output modified_time, output name_offset, output data_offset,
		output status, output file_count, output last_of_run,
		input ready
	);
	modport sink(
		input valid, input record_kind, input entry_index,
		input uncompressed_size, input compressed_size, input data_checksum,
		input modified_time, input name_offset, input data_offset,
		input status, input file_count, input last_of_run,
		output ready
	);
endinterface

`default_nettype wire

// File: src/ahp_front.sv
// ----------------------------------------------------------------------------
// ahp_front
// Takes archive bytes, tracks the header layout, runs the header CRC and
// pushes one command per byte that produces records.
// ----------------------------------------------------------------------------
`default_nettype none

module ahp_front #(
	parameter int OFFSET_BITS = ahp_pkg::OFFSET_BITS_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	ahp_cfg_if.sink        cfg,
	ahp_byte_if.sink       byte_in,
	output logic           push_valid,
	input  wire            push_ready,
	output ahp_pkg::cmd_t  push_data
);

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

	logic [15:0]                  max_files_q;
	ahp_pkg::phase_t              phase_q, phase_n;
	logic [4:0]                   pos_q, pos_n;
	logic [OFFSET_BITS-1:0]       off_q, off_inc;
	logic [31:0]                  crc_q, crc_n, crc_upd;
	logic [31:0]                  count_q, count_n;
	logic [15:0]                  done_q, done_n;
	logic [63:0]                  shift_q, shift_n, shifted;
	logic [31:0]                  f0_q, f0_n, f1_q, f1_n, f2_q, f2_n;
	logic [OFFSET_BITS-1:0]       name_off_q, name_off_n;
	logic [32:0]                  sum_q, sum_n, seen_q, seen_n;
	logic [33:0]                  sum_add;
	ahp_pkg::status_t             err_q, err_n, st;
	logic                         emit_entry;
	logic                         accept;
	logic [7:0]                   b;

	assign cfg.ready     = 1'b1;
	assign byte_in.ready = push_ready;
	assign accept        = byte_in.valid && push_ready;
	assign b             = byte_in.data_byte;

	assign crc_upd = ahp_pkg::crc_byte(crc_q, b);
	assign shifted = {b, shift_q[63:8]};
	assign off_inc = (off_q == OFF_MAX) ? off_q : off_q + OFFSET_BITS'(1);
	assign sum_add = {1'b0, sum_q} + {2'b00, f1_q};

	always_comb begin
		phase_n    = phase_q;
		pos_n      = pos_q;
		crc_n      = crc_q;
		count_n    = count_q;
		done_n     = done_q;
		shift_n    = shift_q;
		f0_n       = f0_q;
		f1_n       = f1_q;
		f2_n       = f2_q;
		name_off_n = name_off_q;
		sum_n      = sum_q;
		seen_n     = seen_q;
		err_n      = err_q;
		emit_entry = 1'b0;
		unique case (phase_q)
			ahp_pkg::PH_MAGIC: begin
				crc_n   = crc_upd;
				shift_n = shifted;
				if (pos_q == ahp_pkg::WORD_LAST) begin
					pos_n = '0;
					if (shifted[63:32] != ahp_pkg::ARC_MAGIC) begin
						err_n   = ahp_pkg::ST_BAD_MAGIC;
						phase_n = ahp_pkg::PH_FAIL;
					end else begin
						phase_n = ahp_pkg::PH_COUNT;
					end
				end else begin
					pos_n = pos_q + 5'd1;
				end
			end
			ahp_pkg::PH_COUNT: begin
				crc_n   = crc_upd;
				shift_n = shifted;
				if (pos_q == ahp_pkg::WORD_LAST) begin
					pos_n   = '0;
					count_n = shifted[63:32];
					if (shifted[63:32] > {16'd0, max_files_q}) begin
						err_n   = ahp_pkg::ST_TOO_MANY;
						phase_n = ahp_pkg::PH_FAIL;
					end else if (shifted[63:32] == 32'd0) begin
						phase_n = ahp_pkg::PH_HCRC;
					end else begin
						phase_n = ahp_pkg::PH_FIXED;
					end
				end else begin
					pos_n = pos_q + 5'd1;
				end
			end
			ahp_pkg::PH_FIXED: begin
				crc_n   = crc_upd;
				shift_n = shifted;
				if (pos_q == ahp_pkg::FLD0_LAST) begin
					f0_n = shifted[63:32];
				end else if (pos_q == ahp_pkg::FLD1_LAST) begin
					f1_n = shifted[63:32];
				end else if (pos_q == ahp_pkg::FLD2_LAST) begin
					f2_n = shifted[63:32];
				end
				if (pos_q >= ahp_pkg::FIXED_LAST) begin
					pos_n      = '0;
					name_off_n = off_inc;
					phase_n    = ahp_pkg::PH_NAME;
				end else begin
					pos_n = pos_q + 5'd1;
				end
			end
			ahp_pkg::PH_NAME: begin
				crc_n = crc_upd;
				if (b == 8'd0) begin
					emit_entry = 1'b1;
					sum_n      = sum_add[33] ? ahp_pkg::SUM_MAX : sum_add[32:0];
					done_n     = done_q + 16'd1;
					pos_n      = '0;
					if ({16'd0, done_n} == count_q) begin
						phase_n = ahp_pkg::PH_HCRC;
					end else begin
						phase_n = ahp_pkg::PH_FIXED;
					end
				end
			end
			ahp_pkg::PH_HCRC: begin
				shift_n = shifted;
				if (pos_q == ahp_pkg::WORD_LAST) begin
					pos_n = '0;
					if (shifted[63:32] != ~crc_q) begin
						err_n   = ahp_pkg::ST_HCRC;
						phase_n = ahp_pkg::PH_FAIL;
					end else begin
						phase_n = ahp_pkg::PH_DATA;
					end
				end else begin
					pos_n = pos_q + 5'd1;
				end
			end
			ahp_pkg::PH_DATA: begin
				seen_n = (seen_q == ahp_pkg::SUM_MAX) ? seen_q : seen_q + 33'd1;
			end
			default: begin
			end
		endcase
	end

	// final status
	always_comb begin
		if (off_q < OFFSET_BITS'(ahp_pkg::START_LEN - 1)) begin
			st = ahp_pkg::ST_TRUNC;
		end else if (err_n != ahp_pkg::ST_OK) begin
			st = err_n;
		end else if (phase_n == ahp_pkg::PH_DATA) begin
			st = (sum_n != ahp_pkg::SUM_MAX && seen_n == sum_n) ?
				ahp_pkg::ST_OK : ahp_pkg::ST_LEN;
		end else begin
			st = ahp_pkg::ST_TRUNC;
		end
	end

	assign push_valid = accept && (emit_entry || byte_in.is_last);

	always_comb begin
		push_data                   = '0;
		push_data.has_entry         = emit_entry;
		push_data.has_status        = byte_in.is_last;
		push_data.entry_index       = done_q;
		push_data.uncompressed_size = f0_q;
		push_data.compressed_size   = f1_q;
		push_data.data_checksum     = f2_q;
		push_data.modified_time     = shift_q;
		push_data.name_offset       = 32'(name_off_q);
		push_data.data_offset       = sum_q[31:0];
		push_data.status            = st;
		push_data.file_count        = count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_files_q <= ahp_pkg::MAX_FILES_RST;
		end else if (cfg.valid) begin
			max_files_q <= cfg.max_files;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ahp_pkg::PH_MAGIC;
			pos_q      <= '0;
			off_q      <= '0;
			crc_q      <= ahp_pkg::CRC_INIT;
			count_q    <= '0;
			done_q     <= '0;
			shift_q    <= '0;
			f0_q       <= '0;
			f1_q       <= '0;
			f2_q       <= '0;
			name_off_q <= '0;
			sum_q      <= '0;
			seen_q     <= '0;
			err_q      <= ahp_pkg::ST_OK;
		end else if (accept) begin
			if (byte_in.is_last) begin
				phase_q    <= ahp_pkg::PH_MAGIC;
				pos_q      <= '0;
				off_q      <= '0;
				crc_q      <= ahp_pkg::CRC_INIT;
				count_q    <= '0;
				done_q     <= '0;
				shift_q    <= '0;
				f0_q       <= '0;
				f1_q       <= '0;
				f2_q       <= '0;
				name_off_q <= '0;
				sum_q      <= '0;
				seen_q     <= '0;
				err_q      <= ahp_pkg::ST_OK;
			end else begin
				phase_q    <= phase_n;
				pos_q      <= pos_n;
				off_q      <= off_inc;
				crc_q      <= crc_n;
				count_q    <= count_n;
				done_q     <= done_n;
				shift_q    <= shift_n;
				f0_q       <= f0_n;
				f1_q       <= f1_n;
				f2_q       <= f2_n;
				name_off_q <= name_off_n;
				sum_q      <= sum_n;
				seen_q     <= seen_n;
				err_q      <= err_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/ahp_queue.sv
// ----------------------------------------------------------------------------
// ahp_queue
// Short register queue of commands between the byte front and the record
// back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ahp_queue #(
	parameter int DEPTH = ahp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push_valid,
	output logic                push_ready,
	input  wire ahp_pkg::cmd_t  push_data,
	output logic                pop_valid,
	input  wire                 pop_ready,
	output ahp_pkg::cmd_t       pop_data
);

	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

	ahp_pkg::cmd_t         slot_q [DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  do_push, do_pop;

	assign push_ready = (cnt_q != CNT_BITS'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: src/ahp_back.sv
// ----------------------------------------------------------------------------
// ahp_back
// Turns each queued command into its entry record and, on the final byte,
// the status record.
// ----------------------------------------------------------------------------
`default_nettype none

module ahp_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	output logic                head_pop,
	input  wire ahp_pkg::cmd_t  head,
	ahp_rec_if.source           rec_out
);

	logic sent_entry_q;
	logic entry_turn;
	logic last_rec;
	logic take;

	assign entry_turn = head.has_entry && !sent_entry_q;
	assign last_rec   = !entry_turn || !head.has_status;
	assign take       = head_valid && rec_out.ready;
	assign head_pop   = take && last_rec;

	assign rec_out.valid       = head_valid;
	assign rec_out.last_of_run = last_rec;
	assign rec_out.file_count  = head.file_count;

	always_comb begin
		if (entry_turn) begin
			rec_out.record_kind       = ahp_pkg::RK_ENTRY;
			rec_out.entry_index       = head.entry_index;
			rec_out.uncompressed_size = head.uncompressed_size;
			rec_out.compressed_size   = head.compressed_size;
			rec_out.data_checksum     = head.data_checksum;
			rec_out.modified_time     = head.modified_time;
			rec_out.name_offset       = head.name_offset;
			rec_out.data_offset       = head.data_offset;
			rec_out.status            = ahp_pkg::ST_OK;
		end else begin
			rec_out.record_kind       = ahp_pkg::RK_STATUS;
			rec_out.entry_index       = '0;
			rec_out.uncompressed_size = '0;
			rec_out.compressed_size   = '0;
			rec_out.data_checksum     = '0;
			rec_out.modified_time     = '0;
			rec_out.name_offset       = '0;
			rec_out.data_offset       = '0;
			rec_out.status            = head.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_entry_q <= 1'b0;
		end else if (take) begin
			sent_entry_q <= !last_rec;
		end
	end

endmodule

`default_nettype wire

// File: src/archive_header_parser.sv
// ----------------------------------------------------------------------------
// archive_header_parser
// Streaming header parser: magic and file count check, per-entry records,
// header CRC-32 check and a final status record per archive.
// ----------------------------------------------------------------------------
// Takes one archive byte per clock cycle while the queue has room, with
// is_last on the final byte of each archive. A byte is processed in the cycle
// it is accepted; its records follow those of earlier bytes. A byte that ends
// an entry name gives one entry record, the final byte gives a status record,
// and a final byte that also ends a name gives both, entry first, occupying
// two output transactions. A queue of QUEUE_DEPTH commands sits between the
// byte front end and the record back end, so the input keeps flowing while the
// output is stalled until that queue fills. After the final byte all parse
// state returns to its reset value; max_files keeps its programmed value.
// ----------------------------------------------------------------------------
`default_nettype none

module archive_header_parser #(
	parameter int OFFSET_BITS = ahp_pkg::OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH = ahp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	ahp_cfg_if.sink    cfg,
	ahp_byte_if.sink   byte_in,
	ahp_rec_if.source  rec_out
);

	logic           push_valid, push_ready;
	ahp_pkg::cmd_t  push_data;
	logic           head_valid, head_pop;
	ahp_pkg::cmd_t  head;

	ahp_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.byte_in   (byte_in),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	ahp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (head_valid),
		.pop_ready (head_pop),
		.pop_data  (head)
	);

	ahp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_pop  (head_pop),
		.head      (head),
		.rec_out   (rec_out)
	);

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for archive_header_parser. A short table of directed
// bytes comes first, then generated archive images (clean ones, broken ones
// and plain noise) under several max_files settings, idle and stall patterns. Every
// accepted byte runs through a bit-accurate header parse model, and each
// record transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_BYTES  = 170;

	typedef enum int {
		AK_GOOD,
		AK_LEN,
		AK_HCRC,
		AK_TRUNC,
		AK_NUL_END,
		AK_TOO_MANY,
		AK_AT_LIMIT,
		AK_MAGIC,
		AK_SAT,
		AK_NOISE,
		AK_COUNT
	} arch_kind_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] idx;
		logic [31:0] usz;
		logic [31:0] csz;
		logic [31:0] dcrc;
		logic [63:0] mtime;
		logic [31:0] noff;
		logic [31:0] doff;
		logic [2:0]  st;
		logic [31:0] fcount;
		logic        lor;
	} arch_rec_t;

	typedef struct packed {
		logic [7:0]       b;
		logic             last;
		logic             typed;
		ahp_pkg::status_t st;
		logic [31:0]      cnt;
	} dir_row_t;

	logic clk;
	logic arst_n;

	ahp_cfg_if  cfg_ch();
	ahp_byte_if byte_ch();
	ahp_rec_if  rec_ch();

	archive_header_parser u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.byte_in(byte_ch),
		.rec_out(rec_ch)
	);

	// short image, short image with wrong magic, count overflow, bad magic
	dir_row_t dir_tab [0:23] = '{
		'{8'hFF, 1'b1, 1'b1, ahp_pkg::ST_TRUNC, 32'd0},
		'{8'h00, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'hFF, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'h00, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'hFF, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'h00, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'hFF, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'h00, 1'b1, 1'b1, ahp_pkg::ST_TRUNC, 32'd0},
		'{8'h41, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'h53, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'h7A, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'h4C, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'hFF, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'hFF, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'hFF, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'hFF, 1'b1, 1'b1, ahp_pkg::ST_TOO_MANY, 32'hFFFF_FFFF},
		'{8'h41, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'h53, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'h7A, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'h4D, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'h00, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'h00, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'h00, 1'b0, 1'b0, ahp_pkg::ST_OK, 32'd0},
		'{8'h00, 1'b1, 1'b1, ahp_pkg::ST_BAD_MAGIC, 32'd0}
	};

	logic [15:0] cfg_plan [0:7] = '{16'd4, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd128, 16'd3, 16'hFFFF};

	// parse model state
	logic [15:0]      limit_files;
	ahp_pkg::phase_t  hdr_phase;
	int               hdr_pos;
	logic [31:0]      hdr_off;
	logic [31:0]      hdr_crc;
	logic [31:0]      hdr_count;
	logic [15:0]      hdr_done;
	logic [63:0]      hdr_shift;
	logic [31:0]      hdr_usz;
	logic [31:0]      hdr_csz;
	logic [31:0]      hdr_dcrc;
	logic [31:0]      hdr_name_off;
	logic [32:0]      hdr_size_sum;
	logic [32:0]      hdr_data_seen;
	ahp_pkg::status_t hdr_err;

	arch_rec_t   pending_records [$];
	logic [7:0]  img [$];

	logic             row_typed;
	ahp_pkg::status_t row_st;
	logic [31:0]      row_cnt;

	logic [15:0] gen_max;
	int          idle_pct;
	int          stall_pct;
	int          phase_bytes;
	int          mismatch_count;
	int          cycle_cnt = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c;
		for (int i = 0; i < 8; i++)
			r = (r >> 1) ^ (ahp_pkg::CRC_POLY & {32{r[0] ^ b[i]}});
		return r;
	endfunction

	function automatic logic [32:0] sum_sat(input logic [32:0] a, input logic [32:0] b);
		logic [33:0] s;
		s = a + b;
		return (s > ahp_pkg::SUM_MAX) ? ahp_pkg::SUM_MAX : s[32:0];
	endfunction

	function automatic logic [31:0] next_offset(input logic [31:0] o);
		return (o == 32'hFFFF_FFFF) ? o : o + 32'd1;
	endfunction

	task automatic reset_parse();
		hdr_phase = ahp_pkg::PH_MAGIC;
		hdr_pos = 0;
		hdr_off = '0;
		hdr_crc = ahp_pkg::CRC_INIT;
		hdr_count = '0;
		hdr_done = '0;
		hdr_shift = '0;
		hdr_usz = '0;
		hdr_csz = '0;
		hdr_dcrc = '0;
		hdr_name_off = '0;
		hdr_size_sum = '0;
		hdr_data_seen = '0;
		hdr_err = ahp_pkg::ST_OK;
	endtask

	task automatic parse_archive_byte(input logic [7:0] b, input logic last);
		arch_rec_t        ent;
		arch_rec_t        stat;
		logic             ent_valid;
		ahp_pkg::status_t st_code;
		ent = '0;
		stat = '0;
		ent_valid = 1'b0;
		case (hdr_phase)
			ahp_pkg::PH_MAGIC, ahp_pkg::PH_COUNT: begin
				hdr_crc = crc_step(hdr_crc, b);
				hdr_shift = {b, hdr_shift[63:8]};
				hdr_pos++;
				if (hdr_pos == 4) begin
					hdr_pos = 0;
					if (hdr_phase == ahp_pkg::PH_MAGIC) begin
						if (hdr_shift[63:32] != ahp_pkg::ARC_MAGIC) begin
							hdr_err = ahp_pkg::ST_BAD_MAGIC;
							hdr_phase = ahp_pkg::PH_FAIL;
						end else begin
							hdr_phase = ahp_pkg::PH_COUNT;
						end
					end else begin
						hdr_count = hdr_shift[63:32];
						if (hdr_count > {16'd0, limit_files}) begin
							hdr_err = ahp_pkg::ST_TOO_MANY;
							hdr_phase = ahp_pkg::PH_FAIL;
						end else if (hdr_count == 0) begin
							hdr_phase = ahp_pkg::PH_HCRC;
						end else begin
							hdr_phase = ahp_pkg::PH_FIXED;
						end
					end
				end
			end
			ahp_pkg::PH_FIXED: begin
				hdr_crc = crc_step(hdr_crc, b);
				hdr_shift = {b, hdr_shift[63:8]};
				if (hdr_pos == ahp_pkg::FLD0_LAST)
					hdr_usz = hdr_shift[63:32];
				else if (hdr_pos == ahp_pkg::FLD1_LAST)
					hdr_csz = hdr_shift[63:32];
				else if (hdr_pos == ahp_pkg::FLD2_LAST)
					hdr_dcrc = hdr_shift[63:32];
				if (hdr_pos >= ahp_pkg::FIXED_LAST) begin
					hdr_pos = 0;
					hdr_name_off = next_offset(hdr_off);
					hdr_phase = ahp_pkg::PH_NAME;
				end else begin
					hdr_pos++;
				end
			end
			ahp_pkg::PH_NAME: begin
				hdr_crc = crc_step(hdr_crc, b);
				if (b == 8'h00) begin
					ent.kind = ahp_pkg::RK_ENTRY;
					ent.idx = hdr_done;
					ent.usz = hdr_usz;
					ent.csz = hdr_csz;
					ent.dcrc = hdr_dcrc;
					ent.mtime = hdr_shift;
					ent.noff = hdr_name_off;
					ent.doff = hdr_size_sum[31:0];
					ent.st = ahp_pkg::ST_OK;
					ent.fcount = hdr_count;
					ent_valid = 1'b1;
					hdr_size_sum = sum_sat(hdr_size_sum, {1'b0, hdr_csz});
					hdr_done++;
					if ({16'd0, hdr_done} == hdr_count)
						hdr_phase = ahp_pkg::PH_HCRC;
					else
						hdr_phase = ahp_pkg::PH_FIXED;
					hdr_pos = 0;
				end
			end
			ahp_pkg::PH_HCRC: begin
				hdr_shift = {b, hdr_shift[63:8]};
				hdr_pos++;
				if (hdr_pos == 4) begin
					hdr_pos = 0;
					if (hdr_shift[63:32] != ~hdr_crc) begin
						hdr_err = ahp_pkg::ST_HCRC;
						hdr_phase = ahp_pkg::PH_FAIL;
					end else begin
						hdr_phase = ahp_pkg::PH_DATA;
					end
				end
			end
			ahp_pkg::PH_DATA: hdr_data_seen = sum_sat(hdr_data_seen, 33'd1);
			default: ;
		endcase

		if (last) begin
			if ({1'b0, hdr_off} + 33'd1 < ahp_pkg::START_LEN)
				st_code = ahp_pkg::ST_TRUNC;
			else if (hdr_err != ahp_pkg::ST_OK)
				st_code = hdr_err;
			else if (hdr_phase != ahp_pkg::PH_DATA)
				st_code = ahp_pkg::ST_TRUNC;
			else if (hdr_size_sum != ahp_pkg::SUM_MAX && hdr_data_seen == hdr_size_sum)
				st_code = ahp_pkg::ST_OK;
			else
				st_code = ahp_pkg::ST_LEN;
			stat.kind = ahp_pkg::RK_STATUS;
			stat.st = st_code;
			stat.fcount = hdr_count;
			stat.lor = 1'b1;
			if (ent_valid)
				pending_records.push_back(ent);
			pending_records.push_back(stat);
			reset_parse();
		end else begin
			hdr_off = next_offset(hdr_off);
			if (ent_valid) begin
				ent.lor = 1'b1;
				pending_records.push_back(ent);
			end
		end
	endtask

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic check_record();
		arch_rec_t got;
		arch_rec_t want;
		got.kind = rec_ch.record_kind;
		got.idx = rec_ch.entry_index;
		got.usz = rec_ch.uncompressed_size;
		got.csz = rec_ch.compressed_size;
		got.dcrc = rec_ch.data_checksum;
		got.mtime = rec_ch.modified_time;
		got.noff = rec_ch.name_offset;
		got.doff = rec_ch.data_offset;
		got.st = rec_ch.status;
		got.fcount = rec_ch.file_count;
		got.lor = rec_ch.last_of_run;
		if (pending_records.size() == 0) begin
			note_mismatch($sformatf("unexpected record kind %0d status %0d", got.kind, got.st));
			return;
		end
		want = pending_records.pop_front();
		check_field("record_kind", got.kind, want.kind);
		check_field("entry_index", got.idx, want.idx);
		check_field("uncompressed_size", got.usz, want.usz);
		check_field("compressed_size", got.csz, want.csz);
		check_field("data_checksum", got.dcrc, want.dcrc);
		check_field("modified_time", got.mtime, want.mtime);
		check_field("name_offset", got.noff, want.noff);
		check_field("data_offset", got.doff, want.doff);
		check_field("status", got.st, want.st);
		check_field("file_count", got.fcount, want.fcount);
		check_field("last_of_run", got.lor, want.lor);
	endtask

	// transaction monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				limit_files = cfg_ch.max_files;
			if (byte_ch.valid && byte_ch.ready) begin
				parse_archive_byte(byte_ch.data_byte, byte_ch.is_last);
				if (row_typed)
					pending_records[$] = '{ahp_pkg::RK_STATUS, 16'd0, 32'd0, 32'd0, 32'd0,
						64'd0, 32'd0, 32'd0, row_st, row_cnt, 1'b1};
			end
			if (rec_ch.valid && rec_ch.ready)
				check_record();
		end
	end

	always @(posedge clk) begin
		if (stall_pct != 0 && $urandom_range(99) < stall_pct)
			rec_ch.ready <= 1'b0;
		else
			rec_ch.ready <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
		input ahp_pkg::status_t st, input logic [31:0] cnt);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			byte_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.is_last <= last;
		row_typed <= typed;
		row_st <= st;
		row_cnt <= cnt;
		do @(posedge clk); while (!byte_ch.ready);
	endtask

	task automatic write_max_files(input logic [15:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.max_files <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_le(input logic [63:0] v, input int nbytes);
		for (int i = 0; i < nbytes; i++)
			img.push_back(v[8*i +: 8]);
	endtask

	task automatic build_archive(input arch_kind_t kind);
		int          n_ent;
		int          cap;
		int          cut;
		int          dlen;
		int          total;
		logic        big;
		logic [31:0] cnt;
		logic [31:0] csz;
		logic [31:0] crc;
		img.delete();
		total = 0;
		big = 1'b0;
		if (kind == AK_NOISE) begin
			repeat ($urandom_range(30, 1)) img.push_back(8'($urandom));
			return;
		end
		if (kind == AK_MAGIC)
			push_le(ahp_pkg::ARC_MAGIC ^ (32'd1 << $urandom_range(31)), 4);
		else
			push_le(ahp_pkg::ARC_MAGIC, 4);
		cap = (gen_max < 4) ? gen_max : 4;
		n_ent = $urandom_range(cap, 0);
		if (kind == AK_SAT)
			n_ent = 3 + $urandom_range(1);
		if (kind == AK_NUL_END && cap > 0)
			n_ent = $urandom_range(cap, 1);
		cnt = n_ent;
		if (kind == AK_TOO_MANY) begin
			if ($urandom_range(1))
				cnt = {16'd0, gen_max} + 32'd1 + $urandom_range(3);
			else
				cnt = $urandom | 32'h0001_0000;
		end
		if (kind == AK_AT_LIMIT) begin
			cnt = gen_max;
			n_ent = (gen_max < 2) ? gen_max : $urandom_range(2);
		end
		push_le(cnt, 4);
		if (kind == AK_MAGIC || kind == AK_TOO_MANY) begin
			repeat ($urandom_range(10)) img.push_back(8'($urandom));
			return;
		end
		for (int e = 0; e < n_ent; e++) begin
			if (kind == AK_SAT) begin
				csz = 32'hFFFF_FFFF;
				big = 1'b1;
			end else if (kind == AK_LEN && $urandom_range(3) == 0) begin
				csz = $urandom;
				big = 1'b1;
			end else begin
				csz = $urandom_range(24);
			end
			total += csz;
			push_le($urandom, 4);
			push_le(csz, 4);
			push_le($urandom, 4);
			push_le({$urandom, $urandom}, 8);
			repeat ($urandom_range(6)) img.push_back(8'($urandom_range(255, 1)));
			img.push_back(8'h00);
		end
		// these end right after the last name terminator, or after the count when they hold no entries
		if (kind == AK_AT_LIMIT || kind == AK_NUL_END)
			return;
		crc = ahp_pkg::CRC_INIT;
		foreach (img[i])
			crc = crc_step(crc, img[i]);
		crc = ~crc;
		if (kind == AK_HCRC)
			crc ^= 32'd1 << $urandom_range(31);
		push_le(crc, 4);
		if (kind == AK_TRUNC) begin
			cut = $urandom_range(img.size() - 1, 1);
			while (img.size() > cut)
				void'(img.pop_back());
			return;
		end
		if (big)
			dlen = $urandom_range(10);
		else if (kind == AK_LEN)
			dlen = (total > 0 && $urandom_range(1)) ? total - 1 : total + 1 + $urandom_range(4);
		else
			dlen = total;
		repeat (dlen) img.push_back(8'($urandom));
	endtask

	task automatic send_archive();
		for (int i = 0; i < img.size(); i++)
			send_byte(img[i], i == img.size() - 1, 1'b0, ahp_pkg::ST_OK, 32'd0);
		phase_bytes += img.size();
	endtask

	function automatic arch_kind_t pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 55) return AK_GOOD;
		if (r < 62) return AK_LEN;
		if (r < 68) return AK_HCRC;
		if (r < 75) return AK_TRUNC;
		if (r < 80) return AK_NUL_END;
		if (r < 85) return AK_TOO_MANY;
		if (r < 88) return AK_AT_LIMIT;
		if (r < 92) return AK_MAGIC;
		if (r < 95) return AK_SAT;
		return AK_NOISE;
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.max_files = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.is_last = 1'b0;
		rec_ch.ready = 1'b0;
		row_typed = 1'b0;
		row_st = ahp_pkg::ST_OK;
		row_cnt = '0;
		idle_pct = 0;
		stall_pct = 0;
		mismatch_count = 0;
		limit_files = ahp_pkg::MAX_FILES_RST;
		gen_max = ahp_pkg::MAX_FILES_RST;
		reset_parse();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_byte(dir_tab[i].b, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].st,
				dir_tab[i].cnt);
		byte_ch.valid <= 1'b0;

		for (int p = 0; p < 8; p++) begin
			wait_drained();
			gen_max = (p == 4) ? 16'($urandom_range(300, 2)) : cfg_plan[p];
			write_max_files(gen_max);
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 68;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 68;
				end
				default: begin
					idle_pct = 10;
					stall_pct = 10;
				end
			endcase
			phase_bytes = 0;
			// one of each archive flavor up front
			if (p == 0) begin
				for (int k = 0; k < AK_COUNT; k++) begin
					build_archive(arch_kind_t'(k));
					send_archive();
				end
			end
			while (phase_bytes < PHASE_BYTES) begin
				build_archive(pick_kind());
				send_archive();
			end
			byte_ch.valid <= 1'b0;
		end

		wait_drained();
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
src/ahp_pkg.sv
src/ahp_ifs.sv
src/ahp_front.sv
src/ahp_queue.sv
src/ahp_back.sv
src/archive_header_parser.sv
dv/tb_top.sv
